>>> rtl/fixed_point_decimal_formatter_top_macros.svh
// Assertion macros shared by the formatter RTL.
// Each macro builds one labeled concurrent assertion that is disabled while
// the active-low reset is asserted.
`ifndef FIXED_POINT_DECIMAL_FORMATTER_TOP_MACROS_SVH
`define FIXED_POINT_DECIMAL_FORMATTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FDF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed (same cycle)");

// The consequent must hold in the cycle after the antecedent.
`define FDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed (next cycle)");

`endif

>>> rtl/fdf_pkg.sv
// Package for the fixed-point decimal formatter.
// Holds the payload types, the job record, character constants and the BCD step.
// No dependencies.
`timescale 1ns / 1ps

package fdf_pkg;

    // Widths of the fields and of the decimal conversion.
    localparam int VALUE_W    = 27;
    localparam int MAG_W      = 26;
    localparam int BCD_DIGITS = 8;
    localparam int ITER_COUNT = MAG_W / 2;
    localparam int ITER_W     = $clog2(ITER_COUNT);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] MAG_LIMIT = 27'd65535999;

    // Character codes.
    localparam logic [7:0] CHAR_ZERO       = 8'h30;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_MINUS      = 8'h2D;
    localparam logic [7:0] FRAC_FIRST_BASE = 8'h86;

    typedef logic [BCD_DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        logic signed [26:0] value_milli;
        logic [1:0]         frac_digits;
        logic [3:0]         field_width;
        logic [7:0]         prefix_symbol;
    } t_fdf_in;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_fdf_out;

    // One converted number waiting for character output.
    typedef struct packed {
        t_bcd       bcd;
        logic       neg;
        logic [1:0] frac_digits;
        logic [3:0] field_width;
        logic [7:0] prefix_symbol;
    } t_fdf_job;

    // One shift-add-3 step: correct every digit, then shift in one binary bit.
    function automatic t_bcd bcd_step(input t_bcd bcd, input logic bit_in);
        t_bcd adj;
        for (int d = 0; d < BCD_DIGITS; d++) begin
            adj[d] = (bcd[d] >= 4'd5) ? (bcd[d] + 4'd3) : bcd[d];
        end
        return t_bcd'({adj[BCD_DIGITS-1:0], bit_in} >> 0);
    endfunction

endpackage

>>> rtl/fdf_front.sv
// Front end of the formatter: takes a number, saturates its magnitude and
// converts it to eight BCD digits, two bits per cycle.
// Depends on fdf_pkg.
`timescale 1ns / 1ps

module fdf_front
    import fdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_fdf_in  i_item,
    output logic     o_busy,
    output logic     o_push,
    output t_fdf_job o_job,
    input  logic     i_full
);

    logic              r_active;
    logic              r_pend;
    logic [ITER_W-1:0] r_iter;
    logic [MAG_W-1:0]  r_bin;
    t_fdf_job          r_job;

    logic [VALUE_W-1:0] raw_u;
    logic               neg;
    logic [VALUE_W-1:0] mag_full;
    logic [MAG_W-1:0]   mag_sat;
    logic               accept;

    // Sign and saturated magnitude of the incoming value.
    assign raw_u    = i_item.value_milli;
    assign neg      = raw_u[VALUE_W-1];
    assign mag_full = neg ? (~raw_u + 27'd1) : raw_u;
    assign mag_sat  = (mag_full > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : mag_full[MAG_W-1:0];

    // A finished job waits only while the queue is full.
    assign o_busy = r_active | (r_pend & i_full);
    assign accept = i_start & ~o_busy;
    assign o_push = r_pend & ~i_full;
    assign o_job  = r_job;

    // Conversion control and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_pend   <= 1'b0;
            r_iter   <= '0;
        end else begin
            if (o_push) begin
                r_pend <= 1'b0;
            end
            if (accept) begin
                r_active            <= 1'b1;
                r_iter              <= '0;
                r_bin               <= mag_sat;
                r_job.bcd           <= '0;
                r_job.neg           <= neg;
                r_job.frac_digits   <= i_item.frac_digits;
                r_job.field_width   <= i_item.field_width;
                r_job.prefix_symbol <= i_item.prefix_symbol;
            end else if (r_active) begin
                r_job.bcd <= bcd_step(bcd_step(r_job.bcd, r_bin[MAG_W-1]), r_bin[MAG_W-2]);
                r_bin     <= {r_bin[MAG_W-3:0], 2'b00};
                if (r_iter == ITER_W'(ITER_COUNT - 1)) begin
                    r_active <= 1'b0;
                    r_pend   <= 1'b1;
                end else begin
                    r_iter <= r_iter + 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/fdf_queue.sv
// Two-entry job queue between the converter and the character sequencer.
// Depends on fdf_pkg.
`timescale 1ns / 1ps

module fdf_queue
    import fdf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_fdf_job i_job,
    output logic     o_full,
    input  logic     i_pop,
    output t_fdf_job o_job,
    output logic     o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_fdf_job          r_entry [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_entry[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/fdf_back.sv
// Back end of the formatter: takes converted jobs and emits the characters
// one per cycle: padding, symbol, sign, integer digits, fraction digits.
// Depends on fdf_pkg.
`timescale 1ns / 1ps

module fdf_back
    import fdf_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 15
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_fdf_job i_job,
    output logic     o_pop,
    output logic     o_strobe,
    output t_fdf_out o_result
);

    localparam logic [3:0] WIDTH_CAP = (MAX_FIELD_WIDTH > 15) ? 4'd15 : 4'(MAX_FIELD_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_SYM,
        S_MINUS,
        S_INT,
        S_FRAC
    } t_state;

    t_state     r_state;
    logic       r_strobe;
    t_fdf_out   r_result;
    t_bcd       r_digits;
    logic [3:0] r_pad;
    logic [7:0] r_sym;
    logic       r_has_sym;
    logic       r_neg;
    logic [1:0] r_dec;
    logic [2:0] r_int_idx;
    logic [1:0] r_frac_cnt;

    logic       has_sym;
    logic [2:0] nd;
    logic [3:0] natural_len;
    logic [3:0] width_c;
    logic [3:0] pad;
    t_state     first_state;
    t_state     after_pad;
    logic [3:0] int_digit;
    logic [3:0] frac_digit;

    // Length of the number and the padding in front of it.
    always_comb begin
        has_sym = (i_job.prefix_symbol != 8'd0);
        if (i_job.bcd[7] != 4'd0) begin
            nd = 3'd5;
        end else if (i_job.bcd[6] != 4'd0) begin
            nd = 3'd4;
        end else if (i_job.bcd[5] != 4'd0) begin
            nd = 3'd3;
        end else if (i_job.bcd[4] != 4'd0) begin
            nd = 3'd2;
        end else begin
            nd = 3'd1;
        end
        natural_len = {3'd0, has_sym} + {3'd0, i_job.neg} + {1'b0, nd}
                    + {2'd0, i_job.frac_digits};
        width_c = (i_job.field_width > WIDTH_CAP) ? WIDTH_CAP : i_job.field_width;
        pad     = (width_c > natural_len) ? (width_c - natural_len) : 4'd0;
        if (pad != 4'd0) begin
            first_state = S_PAD;
        end else if (has_sym) begin
            first_state = S_SYM;
        end else if (i_job.neg) begin
            first_state = S_MINUS;
        end else begin
            first_state = S_INT;
        end
    end

    // Segment that follows the padding of the current job.
    always_comb begin
        if (r_has_sym) begin
            after_pad = S_SYM;
        end else if (r_neg) begin
            after_pad = S_MINUS;
        end else begin
            after_pad = S_INT;
        end
    end

    assign int_digit  = r_digits[3'd3 + r_int_idx];
    assign frac_digit = r_digits[3'd2 - {1'b0, r_frac_cnt}];

    assign o_pop    = (r_state == S_IDLE) & ~i_empty;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // Character sequencer with registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_strobe <= 1'b0;
                    if (!i_empty) begin
                        r_digits   <= i_job.bcd;
                        r_pad      <= pad;
                        r_sym      <= i_job.prefix_symbol;
                        r_has_sym  <= has_sym;
                        r_neg      <= i_job.neg;
                        r_dec      <= i_job.frac_digits;
                        r_int_idx  <= nd - 3'd1;
                        r_frac_cnt <= 2'd0;
                        r_state    <= first_state;
                    end
                end
                S_PAD: begin
                    r_strobe           <= 1'b1;
                    r_result.char_code <= CHAR_SPACE;
                    r_result.last_char <= 1'b0;
                    r_pad              <= r_pad - 4'd1;
                    if (r_pad == 4'd1) begin
                        r_state <= after_pad;
                    end
                end
                S_SYM: begin
                    r_strobe           <= 1'b1;
                    r_result.char_code <= r_sym;
                    r_result.last_char <= 1'b0;
                    r_state            <= r_neg ? S_MINUS : S_INT;
                end
                S_MINUS: begin
                    r_strobe           <= 1'b1;
                    r_result.char_code <= CHAR_MINUS;
                    r_result.last_char <= 1'b0;
                    r_state            <= S_INT;
                end
                S_INT: begin
                    r_strobe           <= 1'b1;
                    r_result.char_code <= CHAR_ZERO + {4'd0, int_digit};
                    r_result.last_char <= (r_int_idx == 3'd0) && (r_dec == 2'd0);
                    if (r_int_idx != 3'd0) begin
                        r_int_idx <= r_int_idx - 3'd1;
                    end else if (r_dec == 2'd0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    r_strobe           <= 1'b1;
                    r_result.char_code <= ((r_frac_cnt == 2'd0) ? FRAC_FIRST_BASE : CHAR_ZERO)
                                        + {4'd0, frac_digit};
                    r_result.last_char <= (r_frac_cnt == r_dec - 2'd1);
                    r_frac_cnt         <= r_frac_cnt + 2'd1;
                    if (r_frac_cnt == r_dec - 2'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_strobe <= 1'b0;
                    r_state  <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/fixed_point_decimal_formatter_top.sv
// Usage of the fixed-point decimal formatter.
//
// Input: drive i_item and raise start; the number is taken at the clock edge
// where start is high and busy is low. The value is in thousandths and is
// saturated to 65535.999 in magnitude.
// Output: one character per cycle on o_result while a number is being printed,
// marked by o_strobe; each transfer completes at the edge that ends the strobe
// cycle. last_char marks the final character of a number. The receiver cannot
// stall the output. The converter works through 13 steps of two bits each and
// then hands the job to the queue; the character sequencer loads each job and
// then emits its characters one per cycle.
// A two-entry queue between converter and sequencer lets a new number be taken
// while the previous one is still being printed.
// Reset (synchronous, active low) empties the queue and drops any number in
// flight; no characters come out until a new number is taken.
// Depends on fdf_pkg, fdf_front, fdf_queue, fdf_back and the macro header.
`timescale 1ns / 1ps
`include "fixed_point_decimal_formatter_top_macros.svh"

module fixed_point_decimal_formatter_top
    import fdf_pkg::*;
#(
    parameter int MAX_FIELD_WIDTH = 15
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_fdf_in  i_item,
    output logic     busy,
    output logic     o_strobe,
    output t_fdf_out o_result
);

    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_empty;
    t_fdf_job w_job_in;
    t_fdf_job w_job_out;

    // Converter.
    fdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_full  (w_full)
    );

    // Job queue.
    fdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty)
    );

    // Character sequencer.
    fdf_back #(
        .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_job_out),
        .o_pop    (w_pop),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // A taken number keeps the converter busy in the following cycle.
    `FDF_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // The converter never hands a job to a full queue.
    `FDF_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, w_push, !w_full)

    // The sequencer pauses for a load cycle after the last character of a number.
    `FDF_ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_result.last_char, !o_strobe)

endmodule

>>> sim/tb.sv
// Self-checking testbench for fixed_point_decimal_formatter_top.
// Drives numbers through a start/busy driver and checks every character strobe
// against an in-bench formatter; depends on fdf_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb;
    import fdf_pkg::*;

    localparam int FIELD_CAP   = 15;
    localparam int RANDOM_ITEMS = 470;
    localparam int SETTLE_CYCLES = 48;

    // One number waiting to be sent, with its idle gap and an optional drain.
    typedef struct {
        t_fdf_in     item;
        int unsigned gap;
        bit          drain;
    } t_number_req;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_fdf_in  i_item = '0;
    logic     busy;
    logic     o_strobe;
    t_fdf_out o_result;

    t_number_req number_q[$];
    t_fdf_out    char_q[$];
    int unsigned chars_due = 0;
    int unsigned chars_got = 0;
    int unsigned err_count = 0;
    int unsigned hold_left = 0;
    bit          loaded = 1'b0;

    fixed_point_decimal_formatter_top #(
        .MAX_FIELD_WIDTH(FIELD_CAP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_fdf_out glyph(input logic [7:0] code);
        t_fdf_out c;
        c.char_code = code;
        c.last_char = 1'b0;
        return c;
    endfunction

    // Formats one number into the characters the block must emit, in order.
    function automatic void predict_chars(input t_fdf_in it);
        int unsigned dec_pow[5] = '{1, 10, 100, 1000, 10000};
        logic [27:0] mag;
        logic        neg;
        int unsigned ip, fp, nd, natural, width, pad;
        t_fdf_out    run[$];
        neg = it.value_milli[26];
        mag = neg ? (28'h8000000 - {1'b0, it.value_milli}) : {1'b0, it.value_milli};
        // Magnitudes past 65535.999 clip to it.
        if (mag > {1'b0, MAG_LIMIT})
            mag = {1'b0, MAG_LIMIT};
        ip = mag / 1000;
        fp = mag % 1000;
        nd = 1;
        if (ip > 9) nd = 2;
        if (ip > 99) nd = 3;
        if (ip > 999) nd = 4;
        if (ip > 9999) nd = 5;
        width = (it.field_width > FIELD_CAP) ? FIELD_CAP : it.field_width;
        natural = (it.prefix_symbol != 0) + neg + nd + it.frac_digits;
        pad = (width > natural) ? width - natural : 0;
        for (int k = 0; k < pad; k++)
            run.push_back(glyph(CHAR_SPACE));
        if (it.prefix_symbol != 0)
            run.push_back(glyph(it.prefix_symbol));
        if (neg)
            run.push_back(glyph(CHAR_MINUS));
        for (int k = nd; k > 0; k--)
            run.push_back(glyph(CHAR_ZERO + 8'((ip / dec_pow[k-1]) % 10)));
        // The first fraction digit uses the glyph that carries the point.
        if (it.frac_digits > 0)
            run.push_back(glyph(FRAC_FIRST_BASE + 8'((fp / 100) % 10)));
        if (it.frac_digits > 1)
            run.push_back(glyph(CHAR_ZERO + 8'((fp / 10) % 10)));
        if (it.frac_digits > 2)
            run.push_back(glyph(CHAR_ZERO + 8'(fp % 10)));
        while (run.size() > FIELD_CAP)
            void'(run.pop_back());
        run[run.size()-1].last_char = 1'b1;
        foreach (run[i])
            char_q.push_back(run[i]);
        chars_due += run.size();
    endfunction

    task automatic enqueue_number(input int value, input int fd, input int fw,
                                  input int sym, input int unsigned gap,
                                  input bit drain);
        t_number_req r;
        r.item.value_milli   = value[26:0];
        r.item.frac_digits   = fd[1:0];
        r.item.field_width   = fw[3:0];
        r.item.prefix_symbol = sym[7:0];
        r.gap   = gap;
        r.drain = drain;
        number_q.push_back(r);
    endtask

    // Mix of small values, digit-count boundaries, in-range and full 27-bit values.
    function automatic int pick_value();
        int mag;
        int bounds[10] = '{0, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535};
        case ($urandom_range(0, 4))
            0: mag = $urandom_range(0, 1999);
            1: return $signed($urandom_range(0, 27'h7FFFFFF) << 5) >>> 5;
            2: mag = $urandom_range(0, 65535999);
            3: mag = bounds[$urandom_range(0, 9)] * 1000 + $urandom_range(0, 999);
            default: mag = $urandom_range(0, 99999);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Driver: presents the oldest pending number after its gap (and, if it asks for a
    // drain, after all expected characters are out); a transfer happens at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        logic fire;
        fire = i_rst_n && start && !busy;
        if (fire) begin
            predict_chars(i_item);
            void'(number_q.pop_front());
            loaded = 1'b0;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !fire) begin
            // Keep holding the current number until it is taken.
        end else begin
            if (!loaded && number_q.size() > 0) begin
                hold_left = number_q[0].gap;
                loaded = 1'b1;
            end
            if (loaded && hold_left == 0
                && !(number_q[0].drain && chars_got != chars_due)) begin
                start  <= 1'b1;
                i_item <= number_q[0].item;
            end else begin
                if (loaded && hold_left > 0)
                    hold_left--;
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobe is a transfer and must match the oldest expectation.
    always @(posedge i_clk) begin
        t_fdf_out want;
        if (i_rst_n && o_strobe) begin
            if (char_q.size() == 0) begin
                err_count++;
                $error("unexpected character 0x%02h last=%0b",
                       o_result.char_code, o_result.last_char);
            end else begin
                want = char_q.pop_front();
                if (o_result.char_code !== want.char_code) begin
                    err_count++;
                    $error("char_code: expected 0x%02h, got 0x%02h",
                           want.char_code, o_result.char_code);
                end
                if (o_result.last_char !== want.last_char) begin
                    err_count++;
                    $error("last_char: expected %0b, got %0b",
                           want.last_char, o_result.last_char);
                end
            end
            chars_got <= chars_got + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned gap;
        bit calm;
        // Directed: zero, extremes, saturation, digit boundaries, widths, symbols.
        enqueue_number(0, 0, 0, 0, 0, 0);
        enqueue_number(65535999, 3, 15, 8'h24, 0, 0);
        enqueue_number(-65535999, 3, 15, 8'hFF, 1, 0);
        enqueue_number(-67108864, 2, 15, 0, 0, 0);
        enqueue_number(67108863, 1, 3, 8'h01, 2, 0);
        enqueue_number(65536000, 3, 0, 0, 0, 0);
        enqueue_number(-500, 1, 0, 0, 0, 0);
        enqueue_number(-1, 3, 4, 0, 0, 0);
        enqueue_number(9999, 0, 1, 0, 9, 0);
        enqueue_number(10000, 1, 15, 8'h56, 0, 0);
        enqueue_number(99999, 2, 8, 0, 0, 0);
        enqueue_number(100000, 3, 15, 0, 0, 0);
        enqueue_number(999999, 0, 15, 8'h41, 0, 0);
        enqueue_number(1000000, 1, 2, 0, 3, 0);
        enqueue_number(-9999999, 2, 12, 0, 0, 0);
        enqueue_number(10000000, 3, 10, 8'h80, 0, 0);
        enqueue_number(123456, 0, 0, 0, 0, 1);
        enqueue_number(123456, 1, 0, 0, 0, 0);
        enqueue_number(-123456, 2, 0, 8'h2B, 0, 0);
        enqueue_number(123456, 3, 0, 0, 0, 0);
        enqueue_number(-999, 3, 15, 8'h7F, 5, 0);
        enqueue_number(7, 0, 15, 0, 0, 1);
        // Random: each group of 30 numbers is back-to-back or gapped traffic, chosen at random.
        calm = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 30 == 0)
                calm = ($urandom_range(0, 2) == 0);
            gap = calm ? 0 : $urandom_range(0, 9);
            enqueue_number(pick_value(), $urandom_range(0, 3), $urandom_range(0, 15),
                           $urandom_range(0, 1) ? 0 : $urandom_range(1, 255), gap,
                           $urandom_range(0, 59) == 0);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (number_q.size() != 0 || start || chars_got != chars_due)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && char_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake or lost characters.
    initial begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/fdf_pkg.sv
rtl/fdf_front.sv
rtl/fdf_queue.sv
rtl/fdf_back.sv
rtl/fixed_point_decimal_formatter_top.sv
sim/tb.sv
